// ===== hdl/assert_macros.svh =====
// Assertion helpers, clocked on aclk and quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge.
`define MQFL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("mailbox assertion failed");

// Antecedent implies consequent in the same cycle.
`define MQFL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mailbox assertion failed");

// Antecedent implies consequent in the next cycle.
`define MQFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mailbox assertion failed");

`endif

// ===== hdl/mqfl_pkg.sv =====
package mqfl_pkg;

    // default sizing
    localparam int NUM_BUFFERS_DEF  = 64;
    localparam int NUM_QUEUES_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int PAYLOAD_BITS_DEF = 64;

    // fixed port widths
    localparam int REQ_W      = 2;
    localparam int QUEUE_ID_W = 6;
    localparam int PAYLOAD_W  = 64;
    localparam int STATUS_W   = 2;

    // request codes (code 3 acts as a query)
    localparam logic [REQ_W-1:0] REQ_SEND  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RECV  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd3;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_SLOT,
        ST_DATA
    } state_t;

endpackage

// ===== hdl/mqfl_ram.sv =====
module mqfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mqfl_qmap.sv =====
// Folds the raw queue id onto the configured queue count (restoring steps).
module mqfl_qmap import mqfl_pkg::*; #(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    parameter int QID_W = 6
) (
    input  logic [QUEUE_ID_W-1:0] queue_id,
    output logic [QID_W-1:0]      queue_idx
);

    logic [QUEUE_ID_W-1:0] rem;

    always_comb begin
        rem = queue_id;
        for (int k = QUEUE_ID_W - 1; k >= 0; k--) begin
            if (int'(rem) >= (NUM_QUEUES << k)) begin
                rem = rem - QUEUE_ID_W'(NUM_QUEUES << k);
            end
        end
    end

    assign queue_idx = QID_W'(rem);

endmodule

// ===== hdl/mailbox_queues_with_buffer_free_list_unit.sv =====
// Channel   Dir  Handshake          Payload
// -------   ---  ---------          -------
// request   in   s_valid / s_ready  s_req_type, s_queue_id, s_payload_in
// result    out  m_valid / m_ready  m_status, m_payload_out, m_queue_empty
//
// Send, query and failed requests finish in ST_LOOK; a successful receive also
// passes ST_SLOT and ST_DATA (queue pointer, slot and payload registered RAM reads).
// After reset a clearing pass over max(NUM_BUFFERS, NUM_QUEUES) entries builds the
// free list and zeroes the queue pointers; s_ready stays low meanwhile.
// Results sit in an output register; when it is full and not being taken the
// unit holds its finished request before commit and stops taking requests.
module mailbox_queues_with_buffer_free_list_unit import mqfl_pkg::*; #(
    parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF,
    parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [REQ_W-1:0]      s_req_type,
    input  logic [QUEUE_ID_W-1:0] s_queue_id,
    input  logic [PAYLOAD_W-1:0]  s_payload_in,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [PAYLOAD_W-1:0]  m_payload_out,
    output logic                  m_queue_empty
);

`include "assert_macros.svh"

    // ---------------------------------------------------------------
    // Derived widths
    // ---------------------------------------------------------------
    localparam int BI_W    = $clog2(NUM_BUFFERS);          // buffer index
    localparam int LK_W    = $clog2(NUM_BUFFERS + 1);      // index plus null link
    localparam int QID_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QS_W    = 2 * PTR_W + CNT_W;            // {head, tail, count}
    localparam int SLOTS   = NUM_QUEUES * QUEUE_DEPTH;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int INIT_N  = (NUM_BUFFERS > NUM_QUEUES) ? NUM_BUFFERS : NUM_QUEUES;
    localparam int IC_W    = $clog2(INIT_N);

    localparam logic [LK_W-1:0]  NULL_LINK = LK_W'(NUM_BUFFERS);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [IC_W-1:0]         init_cnt_reg, init_cnt_next;
    logic [LK_W-1:0]         free_head_reg, free_head_next;
    logic [REQ_W-1:0]        req_reg;
    logic [QID_W-1:0]        q_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [QS_W-1:0]         qs_save_reg, qs_save_next;
    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [PAYLOAD_W-1:0]    pout_reg, pout_next;
    logic                    qempty_reg, qempty_next;

    // ---------------------------------------------------------------
    // RAM ports
    // ---------------------------------------------------------------
    logic                    qst_we, qst_re;
    logic [QID_W-1:0]        qst_waddr, qst_raddr;
    logic [QS_W-1:0]         qst_wdata, qst_rdata;

    logic                    lnk_we, lnk_re;
    logic [BI_W-1:0]         lnk_waddr, lnk_raddr;
    logic [LK_W-1:0]         lnk_wdata, lnk_rdata;

    logic                    buf_we, buf_re;
    logic [BI_W-1:0]         buf_waddr, buf_raddr;
    logic [PAYLOAD_BITS-1:0] buf_wdata, buf_rdata;

    logic                    slt_we, slt_re;
    logic [SLOT_AW-1:0]      slt_waddr, slt_raddr;
    logic [BI_W-1:0]         slt_wdata, slt_rdata;

    // ---------------------------------------------------------------
    // Decode of the looked-up queue state
    // ---------------------------------------------------------------
    logic                    accept, out_free, res_load;
    logic [QID_W-1:0]        q_map;
    logic [PTR_W-1:0]        qs_hd, qs_tl;
    logic [CNT_W-1:0]        qs_cnt;
    logic                    is_send, is_recv, q_full, no_free, send_ok;
    logic                    recv_go;
    logic [SLOT_AW-1:0]      q_base;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // requests enter when nothing is pending in memory; a receive in its last
    // cycle has already written back everything
    assign s_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DATA) && out_free);

    assign {qs_hd, qs_tl, qs_cnt} = qst_rdata;
    assign is_send    = (req_reg == REQ_SEND);
    assign is_recv    = (req_reg == REQ_RECV);
    assign q_full     = (qs_cnt >= CNT_FULL);
    assign no_free    = (free_head_reg >= NULL_LINK);
    assign send_ok    = is_send && !q_full && !no_free;
    assign recv_go    = is_recv && (qs_cnt != '0);
    assign q_base     = SLOT_AW'(q_reg) * SLOT_AW'(QUEUE_DEPTH);

    mqfl_qmap #(
        .NUM_QUEUES (NUM_QUEUES),
        .QID_W      (QID_W)
    ) u_qmap (
        .queue_id  (s_queue_id),
        .queue_idx (q_map)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (int'(init_cnt_reg) == INIT_N - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (recv_go) begin
                    state_next = ST_SLOT;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SLOT: begin
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (out_free) begin
                    state_next = accept ? ST_LOOK : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and memory control
    // ---------------------------------------------------------------
    always_comb begin
        init_cnt_next  = init_cnt_reg;
        free_head_next = free_head_reg;
        qs_save_next   = qs_save_reg;
        res_load       = 1'b0;
        status_next    = status_reg;
        pout_next      = pout_reg;
        qempty_next    = qempty_reg;

        // lookups issued on the accepting edge
        qst_re    = accept;
        qst_raddr = q_map;
        lnk_re    = accept;
        lnk_raddr = free_head_reg[BI_W-1:0];

        qst_we    = 1'b0;
        qst_waddr = q_reg;
        qst_wdata = '0;
        lnk_we    = 1'b0;
        lnk_waddr = slt_rdata;
        lnk_wdata = free_head_reg;
        buf_we    = 1'b0;
        buf_waddr = free_head_reg[BI_W-1:0];
        buf_wdata = pay_reg;
        buf_re    = 1'b0;
        buf_raddr = slt_rdata;
        slt_we    = 1'b0;
        slt_waddr = q_base + SLOT_AW'(qs_tl);
        slt_wdata = free_head_reg[BI_W-1:0];
        slt_re    = 1'b0;
        slt_raddr = q_base + SLOT_AW'(qs_hd);

        unique case (state_reg)
            ST_INIT: begin
                // free list chain i -> i+1, queue pointers zero
                init_cnt_next = init_cnt_reg + 1'b1;
                lnk_we    = (int'(init_cnt_reg) < NUM_BUFFERS);
                lnk_waddr = BI_W'(init_cnt_reg);
                lnk_wdata = LK_W'(init_cnt_reg) + 1'b1;
                qst_we    = (int'(init_cnt_reg) < NUM_QUEUES);
                qst_waddr = QID_W'(init_cnt_reg);
                qst_wdata = '0;
            end
            ST_IDLE: begin
            end
            ST_LOOK: begin
                if (recv_go) begin
                    slt_re       = 1'b1;
                    qs_save_next = {next_slot(qs_hd), qs_tl, qs_cnt - 1'b1};
                end else if (out_free) begin
                    res_load    = 1'b1;
                    pout_next   = '0;
                    qempty_next = send_ok ? 1'b0 : (qs_cnt == '0);
                    if (is_send) begin
                        if (q_full) begin
                            status_next = STAT_FULL;
                        end else if (no_free) begin
                            status_next = STAT_NOFREE;
                        end else begin
                            status_next = STAT_OK;
                        end
                    end else if (is_recv) begin
                        status_next = STAT_EMPTY;
                    end else begin
                        status_next = STAT_OK;
                    end
                    if (send_ok) begin
                        // pop free head, fill buffer, enqueue index
                        free_head_next = lnk_rdata;
                        buf_we    = 1'b1;
                        slt_we    = 1'b1;
                        qst_we    = 1'b1;
                        qst_wdata = {qs_hd, next_slot(qs_tl), qs_cnt + 1'b1};
                    end
                end
            end
            ST_SLOT: begin
                // dequeued buffer goes back on the free-list head
                buf_re         = 1'b1;
                lnk_we         = 1'b1;
                free_head_next = LK_W'(slt_rdata);
                qst_we         = 1'b1;
                qst_wdata      = qs_save_reg;
            end
            ST_DATA: begin
                if (out_free) begin
                    res_load    = 1'b1;
                    status_next = STAT_OK;
                    pout_next   = PAYLOAD_W'(buf_rdata);
                    qempty_next = (qs_save_reg[CNT_W-1:0] == '0);
                end
            end
            default: begin
            end
        endcase

        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            free_head_reg <= free_head_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req_type;
            q_reg   <= q_map;
            pay_reg <= s_payload_in[PAYLOAD_BITS-1:0];
        end
        qs_save_reg <= qs_save_next;
        status_reg  <= status_next;
        pout_reg    <= pout_next;
        qempty_reg  <= qempty_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_payload_out = pout_reg;
    assign m_queue_empty = qempty_reg;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    // per-queue {head, tail, count}
    mqfl_ram #(.WIDTH(QS_W), .DEPTH(NUM_QUEUES)) u_qstate_ram (
        .aclk    (aclk),
        .wr_en   (qst_we),
        .wr_addr (qst_waddr),
        .wr_data (qst_wdata),
        .rd_en   (qst_re),
        .rd_addr (qst_raddr),
        .rd_data (qst_rdata)
    );

    // free-list next links
    mqfl_ram #(.WIDTH(LK_W), .DEPTH(NUM_BUFFERS)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (lnk_we),
        .wr_addr (lnk_waddr),
        .wr_data (lnk_wdata),
        .rd_en   (lnk_re),
        .rd_addr (lnk_raddr),
        .rd_data (lnk_rdata)
    );

    // message payloads
    mqfl_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(NUM_BUFFERS)) u_buf_ram (
        .aclk    (aclk),
        .wr_en   (buf_we),
        .wr_addr (buf_waddr),
        .wr_data (buf_wdata),
        .rd_en   (buf_re),
        .rd_addr (buf_raddr),
        .rd_data (buf_rdata)
    );

    // queue slots, queue-major
    mqfl_ram #(.WIDTH(BI_W), .DEPTH(SLOTS)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slt_we),
        .wr_addr (slt_waddr),
        .wr_data (slt_wdata),
        .rd_en   (slt_re),
        .rd_addr (slt_raddr),
        .rd_data (slt_rdata)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MQFL_ASSERT_IMPL(a_res_no_overwrite, res_load, out_free)
    `MQFL_ASSERT_ALWAYS(a_free_head_range, free_head_reg <= NULL_LINK)
    `MQFL_ASSERT_NEXT(a_slot_then_data, state_reg == ST_SLOT, state_reg == ST_DATA)
    `MQFL_ASSERT_IMPL(a_empty_status_flag, m_valid && (m_status == STAT_EMPTY), m_queue_empty)

endmodule

// ===== dv/tb_mailbox_queues_with_buffer_free_list_unit.sv =====
module tb_mailbox_queues_with_buffer_free_list_unit;
    import mqfl_pkg::*;

    // Block sizing (the DUT runs with its defaults)
    localparam int NB     = NUM_BUFFERS_DEF;
    localparam int NQ     = NUM_QUEUES_DEF;
    localparam int DEPTH  = QUEUE_DEPTH_DEF;
    localparam int IDX_W  = $clog2(NB);
    localparam int LINK_W = $clog2(NB) + 1;      // one more code for the null link
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NB);

    // Code 3 has no package name; the block treats it as a query
    localparam logic [REQ_W-1:0] REQ_ALT_QUERY = 2'd3;

    localparam int RANDOM_ITEMS = 500;
    localparam int TAIL_CYCLES  = 20;    // generous margin after the last reply
    localparam int STALL_LIMIT  = 2000;  // idle cycles, covers the clearing pass too

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] payload;
        logic                 empty;
    } reply_t;

    typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_kind_t;

    // Scoreboard: shadow copy of the mailbox state plus the replies still owed
    class mailbox_tracker;
        logic [LINK_W-1:0]    free_head;
        logic [LINK_W-1:0]    free_link [NB];
        logic [PAYLOAD_W-1:0] buf_data  [NB];
        logic [IDX_W-1:0]     slot_buf  [NQ][DEPTH];
        logic [PTR_W-1:0]     rd_ptr    [NQ];
        logic [PTR_W-1:0]     wr_ptr    [NQ];
        logic [CNT_W-1:0]     fill      [NQ];
        reply_t               due [$];
        int                   mismatches;

        function new();
            free_head  = '0;
            mismatches = 0;
            for (int i = 0; i < NB; i++) begin
                free_link[i] = LINK_W'(i + 1);   // last one lands on the null link
                buf_data[i]  = '0;
            end
            for (int q = 0; q < NQ; q++) begin
                rd_ptr[q] = '0;
                wr_ptr[q] = '0;
                fill[q]   = '0;
                for (int s = 0; s < DEPTH; s++)
                    slot_buf[q][s] = '0;
            end
        endfunction

        function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
            return (p == DEPTH - 1) ? '0 : p + 1'b1;
        endfunction

        // Advance the shadow state by one request and return its reply
        function reply_t predict_reply(logic [REQ_W-1:0] req, logic [QUEUE_ID_W-1:0] qid,
                                       logic [PAYLOAD_W-1:0] data);
            reply_t           r;
            int               qi;
            logic [IDX_W-1:0] b;
            r.status  = STAT_OK;
            r.payload = '0;
            qi = int'(qid) % NQ;
            if (req == REQ_SEND) begin
                if (fill[qi] >= DEPTH) begin
                    r.status = STAT_FULL;         // fullness wins over pool exhaustion
                end else if (free_head >= NULL_LINK) begin
                    r.status = STAT_NOFREE;
                end else begin
                    b                      = free_head[IDX_W-1:0];
                    free_head              = free_link[b];
                    buf_data[b]            = data;
                    slot_buf[qi][wr_ptr[qi]] = b;
                    wr_ptr[qi]             = step_ptr(wr_ptr[qi]);
                    fill[qi]               = fill[qi] + 1'b1;
                end
            end else if (req == REQ_RECV) begin
                if (fill[qi] == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    b            = slot_buf[qi][rd_ptr[qi]];
                    rd_ptr[qi]   = step_ptr(rd_ptr[qi]);
                    fill[qi]     = fill[qi] - 1'b1;
                    r.payload    = buf_data[b];
                    free_link[b] = free_head;
                    free_head    = {1'b0, b};
                end
            end
            r.empty = (fill[qi] == 0);
            return r;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [QUEUE_ID_W-1:0] qid,
                                   logic [PAYLOAD_W-1:0] data);
            due.push_back(predict_reply(req, qid, data));
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [PAYLOAD_W-1:0] payload,
                                   logic empty);
            reply_t e;
            if (due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d payload %h",
                         $time, status, payload);
                mismatches++;
                return;
            end
            e = due.pop_front();
            if (status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                mismatches++;
            end
            if (payload !== e.payload) begin
                $display("%0t: payload expected %h actual %h", $time, e.payload, payload);
                mismatches++;
            end
            if (empty !== e.empty) begin
                $display("%0t: queue_empty expected %0b actual %0b", $time, e.empty, empty);
                mismatches++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type;
    logic [QUEUE_ID_W-1:0] s_queue_id;
    logic [PAYLOAD_W-1:0]  s_payload_in;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [PAYLOAD_W-1:0]  m_payload_out;
    logic                  m_queue_empty;

    mailbox_tracker tracker;
    bit             no_idle = 1'b0;   // set per phase: both sides run back to back
    int             random_sent = 0;
    int             idle_cycles = 0;

    mailbox_queues_with_buffer_free_list_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_queue_id    (s_queue_id),
        .s_payload_in  (s_payload_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_payload_out (m_payload_out),
        .m_queue_empty (m_queue_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // One request transfer. The sender may first idle for a randomly drawn gap; with no
    // idle the valid stays high and only the request fields move to the next item.
    task automatic issue(input logic [REQ_W-1:0] req, input logic [QUEUE_ID_W-1:0] qid,
                         input logic [PAYLOAD_W-1:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_queue_id   <= qid;
        s_payload_in <= data;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(req, qid, data);
    endtask

    // Drop valid and wait for every owed reply; always waits on a clock edge
    // so a following valid rise lands in a later time step.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() > 0);
    endtask

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    // One random item shaped by the phase: fill phases push the pool toward
    // exhaustion and queues toward full, drain phases empty them again.
    task automatic random_item(input phase_kind_t kind, input int base, input int span);
        int                    roll;
        int                    send_pct;
        int                    recv_pct;
        logic [REQ_W-1:0]      req;
        logic [QUEUE_ID_W-1:0] qid;
        case (kind)
            PH_FILL: begin
                send_pct = 80;
                recv_pct = 15;
            end
            PH_DRAIN: begin
                send_pct = 15;
                recv_pct = 75;
            end
            default: begin
                send_pct = 45;
                recv_pct = 45;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < send_pct)
            req = REQ_SEND;
        else if (roll < send_pct + recv_pct)
            req = REQ_RECV;
        else
            req = $urandom_range(0, 1) ? REQ_QUERY : REQ_ALT_QUERY;
        qid = QUEUE_ID_W'(base + $urandom_range(0, span - 1));   // wraps past 63 on purpose
        issue(req, qid, rand_payload());
        random_sent++;
    endtask

    // Stimulus
    initial begin
        phase_kind_t kind;
        int          phase_no;
        int          phase_len;
        int          base;
        int          span;

        tracker      = new();
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_QUERY;
        s_queue_id   <= '0;
        s_payload_in <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty queue, round trips at the id and payload extremes,
        // code 3 as a query, and a queue driven past full.
        issue(REQ_QUERY, 6'd0, '0);
        issue(REQ_RECV, 6'd0, '0);
        issue(REQ_SEND, 6'd0, '1);
        issue(REQ_QUERY, 6'd0, '0);
        issue(REQ_RECV, 6'd0, '1);
        issue(REQ_SEND, 6'd63, '0);
        issue(REQ_ALT_QUERY, 6'd63, '1);
        issue(REQ_RECV, 6'd63, '1);
        issue(REQ_RECV, 6'd63, '0);
        for (int i = 0; i <= DEPTH; i++)
            issue(REQ_SEND, 6'd42, (i % 2) ? 64'haaaa_aaaa_aaaa_aaaa : 64'h5555_5555_5555_5555);
        issue(REQ_ALT_QUERY, 6'd42, '1);
        issue(REQ_RECV, 6'd42, '0);
        issue(REQ_RECV, 6'd42, '0);
        issue(REQ_RECV, 6'd21, '0);

        // Pause with nothing in flight before the random part
        hold_until_drained();

        // Random phases; fill comes first so the pool runs dry early on
        phase_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase_no % 3)
                0:       kind = PH_FILL;
                1:       kind = PH_MIXED;
                default: kind = PH_DRAIN;
            endcase
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 100);
            base      = $urandom_range(0, NQ - 1);
            case ($urandom_range(0, 2))
                0:       span = 2;       // queues hit full quickly
                1:       span = 8;       // 64 slots: pool and queues run out together
                default: span = 16;      // pool runs out first
            endcase
            if (kind == PH_MIXED && $urandom_range(0, 1))
                span = NQ;
            for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++)
                random_item(kind, base, span);
            if ($urandom_range(0, 1))
                hold_until_drained();
            phase_no++;
        end

        hold_until_drained();
        no_idle = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: stall for a randomly drawn gap before each result, then take it
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Result check on every transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_status, m_payload_out, m_queue_empty);
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
